### design/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

    // Field widths fixed by the item format.
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned SYM_W   = 8;
    localparam int unsigned CODE_W  = 32;
    localparam int unsigned LEN_W   = 6;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VBITS_W = 4;
    localparam int unsigned FILL_W  = 3;

    // Function codes of an input item.
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

    // Depth of the queue between the front and back parts.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

    // One queued item: a flush, or a code left-aligned at bit CODE_W-1.
    typedef struct packed {
        logic              is_flush;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_entry;

    // Queue status seen by its producer and consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

### design/hcbp_front.sv
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts items, keeps the code table, and sends flushes and non-empty
// encodes to the queue with their codes left-aligned.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_front #(
    parameter int unsigned SYMBOL_COUNT = 256,
    parameter int unsigned CODE_CAP     = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [hcbp_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [hcbp_pkg::SYM_W-1:0]     i_symbol,
    input  wire logic [hcbp_pkg::CODE_W-1:0]    i_code_bits,
    input  wire logic [hcbp_pkg::LEN_W-1:0]     i_code_length,
    output logic                                o_push,
    output hcbp_pkg::t_entry                    o_push_entry,
    input  wire hcbp_pkg::t_q_status            i_q_status
);

    localparam int unsigned IDX_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int unsigned WORD_W = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;

    // Table memory: left-aligned code and capped length per symbol.
    logic [WORD_W-1:0]            r_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]      r_vld;
    logic [WORD_W-1:0]            r_rd_word;

    // Lookup stage registers.
    logic                         r_s1_valid;
    logic                         r_s1_flush;
    logic                         r_s1_hit;

    logic                         accept;
    logic                         in_range;
    logic [IDX_W-1:0]             idx;
    logic [hcbp_pkg::LEN_W-1:0]   cap_len;
    logic [hcbp_pkg::CODE_W-1:0]  aligned;
    logic                         is_load;
    logic                         is_lookup;
    logic                         need_push;
    logic                         s1_adv;
    logic [hcbp_pkg::LEN_W-1:0]   s1_len;

    // Decode of the incoming item.
    assign in_range  = ({1'b0, i_symbol} < (hcbp_pkg::SYM_W+1)'(SYMBOL_COUNT));
    assign idx       = i_symbol[IDX_W-1:0];
    assign cap_len   = (i_code_length > hcbp_pkg::LEN_W'(CODE_CAP)) ?
                       hcbp_pkg::LEN_W'(CODE_CAP) : i_code_length;
    assign aligned   = i_code_bits << (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - cap_len);
    assign is_load   = (i_func == hcbp_pkg::FUNC_LOAD);
    assign is_lookup = (i_func == hcbp_pkg::FUNC_ENCODE) || (i_func == hcbp_pkg::FUNC_FLUSH);

    // The lookup stage moves on when it is empty, drops its item, or can push.
    assign s1_len    = r_rd_word[hcbp_pkg::LEN_W-1:0];
    assign need_push = r_s1_flush || (r_s1_hit && (s1_len != '0));
    assign s1_adv    = !r_s1_valid || !need_push || !i_q_status.full;
    assign o_ready   = s1_adv;
    assign accept    = i_valid && s1_adv;

    // Queue entry built from the lookup stage.
    assign o_push                = r_s1_valid && need_push && !i_q_status.full;
    assign o_push_entry.is_flush = r_s1_flush;
    assign o_push_entry.code     = r_rd_word[WORD_W-1:hcbp_pkg::LEN_W];
    assign o_push_entry.len      = r_s1_flush ? '0 : s1_len;

    // Table memory write on load and registered read on lookup.
    always_ff @(posedge i_clk) begin
        if (accept && is_load && in_range) begin
            r_mem[idx] <= {aligned, cap_len};
        end
        if (accept && is_lookup) begin
            r_rd_word <= r_mem[idx];
        end
    end

    // Entry valid bits and lookup stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_flush <= 1'b0;
            r_s1_hit   <= 1'b0;
        end else begin
            if (accept && is_load && in_range) begin
                r_vld[idx] <= 1'b1;
            end
            if (s1_adv) begin
                r_s1_valid <= accept && is_lookup;
                r_s1_flush <= (i_func == hcbp_pkg::FUNC_FLUSH);
                r_s1_hit   <= in_range && r_vld[idx];
            end
        end
    end

endmodule

`default_nettype wire

### design/hcbp_queue.sv
// ----------------------------------------------------------------------------
// hcbp_queue
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire hcbp_pkg::t_entry i_push_entry,
    input  wire logic             i_pop,
    output hcbp_pkg::t_entry      o_head,
    output hcbp_pkg::t_q_status   o_status
);

    hcbp_pkg::t_entry                r_slot [hcbp_pkg::Q_DEPTH];
    logic [hcbp_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [hcbp_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [hcbp_pkg::Q_PTR_W:0]      r_count;
    logic [hcbp_pkg::Q_PTR_W:0]      n_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_status.full  = (r_count == (hcbp_pkg::Q_PTR_W+1)'(hcbp_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_slot[r_rd_ptr];

    // Occupancy update.
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_entry;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

### design/hcbp_back.sv
// ----------------------------------------------------------------------------
// hcbp_back
// Packs queued codes into bytes, one output byte per cycle while the output is
// accepted, and emits the partial byte on flush.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire hcbp_pkg::t_entry              i_head,
    input  wire hcbp_pkg::t_q_status           i_q_status,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]        o_out_byte,
    output logic [hcbp_pkg::VBITS_W-1:0]       o_valid_bits,
    output logic                               o_last
);

    // Accumulator and the rest of a code that spans several bytes.
    logic [hcbp_pkg::BYTE_W-1:0]   r_acc;
    logic [hcbp_pkg::FILL_W-1:0]   r_fill;
    logic                          r_busy;
    logic [hcbp_pkg::CODE_W-1:0]   r_work;
    logic [hcbp_pkg::LEN_W-1:0]    r_rem;

    // Output register.
    logic                          r_out_valid;
    logic [hcbp_pkg::BYTE_W-1:0]   r_out_byte;
    logic [hcbp_pkg::VBITS_W-1:0]  r_out_vbits;
    logic                          r_out_last;

    logic                          cur_valid;
    logic                          cur_flush;
    logic [hcbp_pkg::CODE_W-1:0]   cur_work;
    logic [hcbp_pkg::LEN_W-1:0]    cur_rem;
    logic                          step;
    logic                          emit;
    logic [hcbp_pkg::LEN_W:0]      total;
    logic [hcbp_pkg::BYTE_W-1:0]   merged;
    logic [3:0]                    take;
    logic [hcbp_pkg::CODE_W-1:0]   work2;
    logic [hcbp_pkg::LEN_W-1:0]    rem2;

    // The current item is the held remainder, else the queue head.
    assign cur_valid = r_busy || !i_q_status.empty;
    assign cur_flush = !r_busy && i_head.is_flush;
    assign cur_work  = r_busy ? r_work : i_head.code;
    assign cur_rem   = r_busy ? r_rem  : i_head.len;
    assign step      = cur_valid && (!r_out_valid || i_ready);
    assign o_pop     = step && !r_busy;

    // Byte assembly for one step.
    assign total  = {1'b0, cur_rem} + (hcbp_pkg::LEN_W+1)'(r_fill);
    assign merged = r_acc | (cur_work[hcbp_pkg::CODE_W-1 -: hcbp_pkg::BYTE_W] >> r_fill);
    assign take   = 4'd8 - {1'b0, r_fill};
    assign work2  = cur_work << take;
    assign rem2   = cur_rem - hcbp_pkg::LEN_W'(take);
    assign emit   = cur_flush || (total >= (hcbp_pkg::LEN_W+1)'(hcbp_pkg::BYTE_W));

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_valid_bits = r_out_vbits;
    assign o_last       = r_out_last;

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (step) begin
            if (cur_flush) begin
                r_out_byte  <= r_acc;
                r_out_vbits <= hcbp_pkg::VBITS_W'(r_fill);
                r_out_last  <= 1'b1;
            end else begin
                r_out_byte  <= merged;
                r_out_vbits <= 4'd8;
                r_out_last  <= (rem2 < hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_W));
            end
        end
        if (step && !cur_flush && (total >= (hcbp_pkg::LEN_W+1)'(hcbp_pkg::BYTE_W))) begin
            r_work <= work2;
            r_rem  <= rem2;
        end
    end

    // Packer state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_fill      <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register fills on a flush or a full byte, else drains on ready.
            if (step && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (step) begin
                if (cur_flush) begin
                    // Flush: emit the partial byte and clear.
                    r_acc       <= '0;
                    r_fill      <= '0;
                    r_busy      <= 1'b0;
                end else if (total >= (hcbp_pkg::LEN_W+1)'(hcbp_pkg::BYTE_W)) begin
                    // A full byte goes out; a short tail stays in the accumulator.
                    if (rem2 < hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_W)) begin
                        r_acc  <= work2[hcbp_pkg::CODE_W-1 -: hcbp_pkg::BYTE_W];
                        r_fill <= rem2[hcbp_pkg::FILL_W-1:0];
                        r_busy <= 1'b0;
                    end else begin
                        r_acc  <= '0;
                        r_fill <= '0;
                        r_busy <= 1'b1;
                    end
                end else begin
                    // Code fits in the partial byte without completing it.
                    r_acc  <= merged;
                    r_fill <= total[hcbp_pkg::FILL_W-1:0];
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

### design/huffman_code_bit_packer.sv
// Path: a table load takes effect for the item accepted after it; the bytes of an encode or
// flush item pass the table read register, the queue and the packer output register.
// Throughput: one item accepted per cycle while the queue has room (4 entries); the packer
// emits one byte per cycle while the output is ready, and an encode yields 0 to 4 bytes.
// Reset: control, accumulator and table entry valid bits clear; the code memory itself is
// not initialized, and entries not yet loaded yield no output.
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman encoder back end: code table, item queue and MSB-first byte packer.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer #(
    parameter int unsigned SYMBOL_COUNT = 256,
    parameter int unsigned MAX_CODE_LEN = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [hcbp_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [hcbp_pkg::SYM_W-1:0]     i_symbol,
    input  wire logic [hcbp_pkg::CODE_W-1:0]    i_code_bits,
    input  wire logic [hcbp_pkg::LEN_W-1:0]     i_code_length,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]         o_out_byte,
    output logic [hcbp_pkg::VBITS_W-1:0]        o_valid_bits,
    output logic                                o_last
);

    localparam int unsigned CODE_CAP =
        (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN : hcbp_pkg::CODE_W;

    logic                  push;
    hcbp_pkg::t_entry      push_entry;
    logic                  pop;
    hcbp_pkg::t_entry      head;
    hcbp_pkg::t_q_status   q_status;

    // Front part: table and item classification.
    hcbp_front #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .CODE_CAP     (CODE_CAP)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .o_push        (push),
        .o_push_entry  (push_entry),
        .i_q_status    (q_status)
    );

    // Queue between the two parts.
    hcbp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_head       (head),
        .o_status     (q_status)
    );

    // Back part: bit packer and output register.
    hcbp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_valid_bits (o_valid_bits),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire
